// File: hw/rtl/wsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hffff;

    localparam logic [3:0] OPCODE_MASK = 4'hf;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [1:0] LAST_KEY_IDX = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_UNMASKED   = 3'd2;
    localparam logic [2:0] ST_LEN64      = 3'd3;
    localparam logic [2:0] ST_SHORT      = 3'd4;
    localparam logic [2:0] ST_OVERFLOW   = 3'd5;

    typedef enum logic [6:0] {
        PH_HDR0  = 7'b0000001,
        PH_HDR1  = 7'b0000010,
        PH_LENHI = 7'b0000100,
        PH_LENLO = 7'b0001000,
        PH_MASK  = 7'b0010000,
        PH_DATA  = 7'b0100000,
        PH_DROP  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  raw_byte;
        logic [7:0]  key_byte;
        logic        done_res;
        logic [2:0]  status;
        logic [3:0]  opcode;
        logic [15:0] payload_length;
    } cmd_t;

endpackage

// File: hw/rtl/wsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_front
// frame header parser: tracks the phase, holds length and mask key, and
// issues one command word per result into the queue
// ----------------------------------------------------------------------------
module wsd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        data_byte,
    input  logic              end_of_buffer,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data,
    input  logic              queue_full,
    output logic              cmd_valid,
    output wsd_pkg::cmd_t     cmd
);

    wsd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      opcode_reg, opcode_next;
    logic [15:0]     length_reg, length_next;
    logic [3:0][7:0] key_reg, key_next;
    logic [15:0]     count_reg, count_next;
    logic            over_reg, over_next;
    logic [15:0]     max_reg;

    logic            accept;
    logic            fin;
    logic [2:0]      fin_st;
    logic            tail;
    logic            has_out;
    logic [15:0]     count_inc;

    assign full      = queue_full;
    assign cfg_ready = 1'b1;
    assign accept    = push && !queue_full;
    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        length_next = length_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        over_next   = over_reg;
        fin         = 1'b0;
        fin_st      = wsd_pkg::ST_OK;
        tail        = 1'b0;
        has_out     = 1'b0;
        case (phase_reg)
            wsd_pkg::PH_HDR0:
            begin
                opcode_next = data_byte[3:0] & wsd_pkg::OPCODE_MASK;
                if (end_of_buffer)
                begin
                    fin    = 1'b1;
                    fin_st = wsd_pkg::ST_SHORT;
                end
                else
                begin
                    phase_next = wsd_pkg::PH_HDR1;
                end
            end
            wsd_pkg::PH_HDR1:
            begin
                if (!data_byte[7])
                begin
                    fin    = 1'b1;
                    fin_st = wsd_pkg::ST_UNMASKED;
                end
                else if (data_byte[6:0] == wsd_pkg::LEN_EXT64)
                begin
                    fin    = 1'b1;
                    fin_st = wsd_pkg::ST_LEN64;
                end
                else
                begin
                    count_next = 16'd0;
                    tail       = 1'b1;
                    if (data_byte[6:0] == wsd_pkg::LEN_EXT16)
                    begin
                        length_next = 16'd0;
                        phase_next  = wsd_pkg::PH_LENHI;
                    end
                    else
                    begin
                        length_next = {9'd0, data_byte[6:0]};
                        phase_next  = wsd_pkg::PH_MASK;
                    end
                end
            end
            wsd_pkg::PH_LENHI:
            begin
                length_next = {data_byte, 8'h00};
                phase_next  = wsd_pkg::PH_LENLO;
                tail        = 1'b1;
            end
            wsd_pkg::PH_LENLO:
            begin
                length_next = length_reg | {8'h00, data_byte};
                phase_next  = wsd_pkg::PH_MASK;
                tail        = 1'b1;
            end
            wsd_pkg::PH_MASK:
            begin
                key_next[count_reg[1:0]] = data_byte;
                count_next = count_inc;
                if (count_reg[1:0] == wsd_pkg::LAST_KEY_IDX)
                begin
                    count_next = 16'd0;
                    over_next  = length_reg > max_reg;
                    if (length_reg == 16'd0)
                    begin
                        fin    = 1'b1;
                        fin_st = wsd_pkg::ST_OK;
                    end
                    else
                    begin
                        phase_next = wsd_pkg::PH_DATA;
                        tail       = 1'b1;
                    end
                end
                else
                begin
                    tail = 1'b1;
                end
            end
            wsd_pkg::PH_DATA:
            begin
                count_next = count_inc;
                has_out    = !over_reg;
                if (count_inc >= length_reg)
                begin
                    fin    = 1'b1;
                    fin_st = over_reg ? wsd_pkg::ST_OVERFLOW : wsd_pkg::ST_OK;
                end
                else if (end_of_buffer)
                begin
                    fin    = 1'b1;
                    fin_st = wsd_pkg::ST_INCOMPLETE;
                end
            end
            wsd_pkg::PH_DROP:
            begin
                if (end_of_buffer)
                begin
                    phase_next = wsd_pkg::PH_HDR0;
                end
            end
            default:
            begin
                phase_next = wsd_pkg::PH_HDR0;
            end
        endcase
        if (tail && end_of_buffer)
        begin
            fin    = 1'b1;
            fin_st = wsd_pkg::ST_INCOMPLETE;
        end
        if (fin)
        begin
            phase_next = end_of_buffer ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DROP;
        end
    end

    always_comb
    begin
        cmd.has_byte       = has_out;
        cmd.raw_byte       = data_byte;
        cmd.key_byte       = key_reg[count_reg[1:0]];
        cmd.done_res       = fin;
        cmd.status         = fin ? fin_st : wsd_pkg::ST_OK;
        cmd.opcode         = opcode_next;
        cmd.payload_length = (fin && fin_st == wsd_pkg::ST_OK) ? length_reg : 16'd0;
        cmd_valid          = accept && (fin || has_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsd_pkg::PH_HDR0;
            opcode_reg <= 4'd0;
            length_reg <= 16'd0;
            key_reg    <= '0;
            count_reg  <= 16'd0;
            over_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            length_reg <= length_next;
            key_reg    <= key_next;
            count_reg  <= count_next;
            over_reg   <= over_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= wsd_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_reg <= cfg_data;
        end
    end

    // payload bytes only come out of the data phase of an accepted frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd.has_byte) |-> (phase_reg == wsd_pkg::PH_DATA && !over_reg))
        else $error("payload byte issued outside data phase");

    // a frame that ends on the last buffer byte returns to header parsing
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd.done_res && end_of_buffer) |=> (phase_reg == wsd_pkg::PH_HDR0))
        else $error("phase not back to header after buffer end");

    // the key index stays inside the four key bytes while collecting the mask
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wsd_pkg::PH_MASK) |-> (count_reg[15:2] == 14'd0))
        else $error("mask byte counter out of range");

endmodule

// File: hw/rtl/wsd_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_cmd_fifo
// short command queue between the parser and the output stage
// ----------------------------------------------------------------------------
module wsd_cmd_fifo
#(
    parameter int DEPTH = wsd_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  wsd_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic          not_empty,
    output wsd_pkg::cmd_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsd_pkg::cmd_t      entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = entry_reg[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // the parser never offers a word into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("write into full queue");

endmodule

// File: hw/rtl/wsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_back
// output stage: unmasks the payload byte and holds the result word
// ----------------------------------------------------------------------------
module wsd_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_avail,
    input  wsd_pkg::cmd_t cmd,
    output logic          cmd_take,
    output logic          empty,
    input  logic          pop,
    output logic          has_byte,
    output logic [7:0]    payload_byte,
    output logic          done_res,
    output logic [2:0]    status,
    output logic [3:0]    opcode,
    output logic [15:0]   payload_length
);

    logic        valid_reg;
    logic        has_reg;
    logic [7:0]  byte_reg;
    logic        done_reg;
    logic [2:0]  status_reg;
    logic [3:0]  opcode_reg;
    logic [15:0] length_reg;

    assign cmd_take = cmd_avail && (!valid_reg || pop);
    assign empty    = !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd_take)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            has_reg    <= cmd.has_byte;
            byte_reg   <= cmd.has_byte ? (cmd.raw_byte ^ cmd.key_byte) : 8'h00;
            done_reg   <= cmd.done_res;
            status_reg <= cmd.status;
            opcode_reg <= cmd.opcode;
            length_reg <= cmd.payload_length;
        end
    end

    assign has_byte       = has_reg;
    assign payload_byte   = byte_reg;
    assign done_res       = done_reg;
    assign status         = status_reg;
    assign opcode         = opcode_reg;
    assign payload_length = length_reg;

endmodule

// File: hw/rtl/websocket_frame_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// client websocket frame deframer: header parse, length check, unmasking
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          data_byte, end_of_buffer
//  result    pop / empty          has_byte, payload_byte, done_res, status,
//                                 opcode, payload_length
//  config    cfg_valid/cfg_ready  cfg_data (max_payload)
//
//  one input byte per cycle while full is low; a result reaches the result ports
//  after it passes through the command queue and then the output register
//  reset clears the parser to the first header byte and max_payload to 65535
//  full rises only when the command queue holds QUEUE_DEPTH waiting words
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core
#(
    parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    output logic        empty,
    input  logic        pop,
    output logic        has_byte,
    output logic [7:0]  payload_byte,
    output logic        done_res,
    output logic [2:0]  status,
    output logic [3:0]  opcode,
    output logic [15:0] payload_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    wsd_pkg::cmd_t front_cmd;
    wsd_pkg::cmd_t queue_cmd;
    logic          front_valid;
    logic          queue_full;
    logic          queue_avail;
    logic          queue_take;

    wsd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .queue_full    (queue_full),
        .cmd_valid     (front_valid),
        .cmd           (front_cmd)
    );

    wsd_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_valid),
        .wr_data   (front_cmd),
        .full      (queue_full),
        .rd_en     (queue_take),
        .not_empty (queue_avail),
        .rd_data   (queue_cmd)
    );

    wsd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_avail      (queue_avail),
        .cmd            (queue_cmd),
        .cmd_take       (queue_take),
        .empty          (empty),
        .pop            (pop),
        .has_byte       (has_byte),
        .payload_byte   (payload_byte),
        .done_res       (done_res),
        .status         (status),
        .opcode         (opcode),
        .payload_length (payload_length)
    );

endmodule
